@@ rtl/core/max_tracking_stack_assert.svh @@
// Assertion macros for the max tracking stack RTL.
// Depends on a clock named clk and an active-low reset named arst_n in the including scope.
`ifndef MAX_TRACKING_STACK_ASSERT_SVH
`define MAX_TRACKING_STACK_ASSERT_SVH

`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define MTS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define MTS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define MTS_ASSERT_NOW(label, ante, cons)
`define MTS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ rtl/core/mts_pkg.sv @@
// Shared types and constants for the max tracking stack.
// Used by the controller, the datapath and the top level; depends on nothing.
package mts_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int DATA_WIDTH  = 32;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	// Operation codes of the func field.
	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} mts_status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP_RD,
		S_EMIT
	} mts_state_t;

	typedef struct packed {
		logic               func;
		logic signed [31:0] value;
	} mts_in_t;

	typedef struct packed {
		logic signed [31:0] max_value;
		logic [6:0]         depth_count;
		logic               empty_res;
		logic [1:0]         status;
	} mts_out_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic        push;
		logic        pop;
		logic        top_load;
		logic        out_load;
		mts_status_t status;
	} mts_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;
		logic empty;
	} mts_stat_t;

endpackage

@@ rtl/core/mts_ctrl.sv @@
// Controller state machine of the max tracking stack.
// Depends on mts_pkg; drives mts_dpath through the command struct.
module mts_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              func,
	output logic              out_valid,
	input  logic              out_ready,
	input  mts_pkg::mts_stat_t stat,
	output mts_pkg::mts_cmd_t  cmd
);

	mts_pkg::mts_state_t  state_q, state_d;
	mts_pkg::mts_status_t status_q;
	logic                 out_valid_q;
	logic                 accept;
	logic                 do_push;
	logic                 do_pop;
	logic                 out_load;

	// Decode the accepted operation against the current stack state.
	assign in_ready = (state_q == mts_pkg::S_IDLE);
	assign accept   = in_valid && in_ready;
	assign do_push  = accept && (func == mts_pkg::FUNC_PUSH) && !stat.full;
	assign do_pop   = accept && (func == mts_pkg::FUNC_POP) && !stat.empty;
	assign out_load = (state_q == mts_pkg::S_EMIT) && (!out_valid_q || out_ready);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mts_pkg::S_IDLE: begin
				if (accept) begin
					state_d = do_pop ? mts_pkg::S_POP_RD : mts_pkg::S_EMIT;
				end
			end
			mts_pkg::S_POP_RD: begin
				state_d = mts_pkg::S_EMIT;
			end
			mts_pkg::S_EMIT: begin
				if (out_load) begin
					state_d = mts_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = mts_pkg::S_IDLE;
			end
		endcase
	end

	// Command outputs to the datapath.
	always_comb begin
		cmd.push     = do_push;
		cmd.pop      = do_pop;
		cmd.top_load = (state_q == mts_pkg::S_POP_RD);
		cmd.out_load = out_load;
		cmd.status   = status_q;
	end

	// State, latched status code and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mts_pkg::S_IDLE;
			status_q    <= mts_pkg::ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if ((func == mts_pkg::FUNC_PUSH) && stat.full) begin
					status_q <= mts_pkg::ST_FULL;
				end else if ((func == mts_pkg::FUNC_POP) && stat.empty) begin
					status_q <= mts_pkg::ST_EMPTY;
				end else begin
					status_q <= mts_pkg::ST_OK;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ rtl/core/mts_dpath.sv @@
// Datapath of the max tracking stack: running-maximum memory, entry count,
// top-of-stack register and result register. Depends on mts_pkg and the assertion header.
`include "max_tracking_stack_assert.svh"

module mts_dpath (
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [31:0] value,
	input  mts_pkg::mts_cmd_t  cmd,
	output mts_pkg::mts_stat_t stat,
	output mts_pkg::mts_out_t  out_data
);

	localparam int DW = mts_pkg::DATA_WIDTH;
	localparam int AW = mts_pkg::ADDR_W;
	localparam int CW = mts_pkg::CNT_W;

	logic signed [DW-1:0] mem [mts_pkg::STACK_DEPTH];
	logic signed [DW-1:0] top_q;
	logic signed [DW-1:0] rd_q;
	logic [CW-1:0]        count_q;
	mts_pkg::mts_out_t    out_q;

	logic signed [DW-1:0] value_dw;
	logic signed [DW-1:0] new_max;
	logic [CW-1:0]        below_idx;

	// The pushed word held at the stack width, and the new running maximum.
	assign value_dw  = DW'(value);
	assign new_max   = ((count_q == '0) || (value_dw > top_q)) ? value_dw : top_q;
	assign below_idx = count_q - CW'(2);

	assign stat.full  = (count_q == CW'(mts_pkg::STACK_DEPTH));
	assign stat.empty = (count_q == '0);

	// Entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.push) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.pop) begin
			count_q <= count_q - CW'(1);
		end
	end

	// Memory write on push; on pop, read the entry that becomes the new top.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[count_q[AW-1:0]] <= new_max;
		end
		if (cmd.pop) begin
			rd_q <= mem[below_idx[AW-1:0]];
		end
	end

	// Top-of-stack maximum, kept in a register so a push compares without a read.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			top_q <= new_max;
		end else if (cmd.top_load) begin
			top_q <= rd_q;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.max_value   <= (count_q == '0) ? 32'sd0 : 32'(top_q);
			out_q.depth_count <= 7'(count_q);
			out_q.empty_res   <= (count_q == '0);
			out_q.status      <= cmd.status;
		end
	end

	assign out_data = out_q;

	`MTS_ASSERT_NOW(a_push_pop_excl, cmd.push, !cmd.pop)
	`MTS_ASSERT_NOW(a_count_range, 1'b1, count_q <= CW'(mts_pkg::STACK_DEPTH))
	`MTS_ASSERT_NEXT(a_push_count, cmd.push, count_q == $past(count_q) + CW'(1))
	`MTS_ASSERT_NEXT(a_pop_count, cmd.pop, count_q == $past(count_q) - CW'(1))

endmodule

@@ rtl/core/max_tracking_stack.sv @@
// Max tracking stack: each operation (push or pop) returns one result holding
// the maximum of the stacked words, the depth, an empty flag and a status. A push
// goes through S_EMIT into the result register; a pop goes through S_POP_RD first, because the entry
// that becomes the new top comes through the registered read port of the stack
// memory. A new operation is taken once the previous result has moved into the
// output register, even if that result has not yet been transferred out; a stalled
// output adds its wait to the next result. There is no clearing pass after reset.
module max_tracking_stack (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mts_pkg::mts_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output mts_pkg::mts_out_t out_data
);

	mts_pkg::mts_cmd_t  cmd;
	mts_pkg::mts_stat_t stat;

	// Sequencing of operations and output handshake.
	mts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (in_data.func),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Stack storage and result formation.
	mts_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.value    (in_data.value),
		.cmd      (cmd),
		.stat     (stat),
		.out_data (out_data)
	);

endmodule
